// ===== src/nnsa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnsa_pkg: shared types and constants of the nearest-neighbor address scaler
// Field widths, register map codes, pipeline stage payload and config bundle.
// ----------------------------------------------------------------------------
package nnsa_pkg;

  // Field widths
  localparam int unsigned COORD_W = 12;                 // dest/src coordinate
  localparam int unsigned DIM_W   = 13;                 // image dimension register
  localparam int unsigned PROD_W  = COORD_W + DIM_W;    // coordinate times dimension
  localparam int unsigned QUO_W   = DIM_W;              // quotient bits, one per stage
  localparam int unsigned INDEX_W = 24;                 // row-major source index
  localparam int unsigned ADDR_W  = 4;                  // APB byte address
  localparam int unsigned DATA_W  = 32;                 // APB data

  // Parameter default and register reset values
  localparam int unsigned MAX_DIM_DEF = 4096;
  localparam logic [DIM_W-1:0] SRC_W_RST = 13'd640;
  localparam logic [DIM_W-1:0] SRC_H_RST = 13'd480;
  localparam logic [DIM_W-1:0] TGT_W_RST = 13'd640;
  localparam logic [DIM_W-1:0] TGT_H_RST = 13'd480;

  // Register map (word index)
  typedef enum logic [1:0] {
    REG_SRC_W = 2'd0,
    REG_SRC_H = 2'd1,
    REG_TGT_W = 2'd2,
    REG_TGT_H = 2'd3
  } reg_idx_t;

  // Configuration bundle
  typedef struct packed {
    logic [DIM_W-1:0] src_w;
    logic [DIM_W-1:0] src_h;
    logic [DIM_W-1:0] tgt_w;
    logic [DIM_W-1:0] tgt_h;
  } cfg_t;

  // Payload carried through the divider stages
  typedef struct packed {
    logic [PROD_W-1:0] rem_c;
    logic [PROD_W-1:0] rem_r;
    logic [QUO_W-1:0]  quo_c;
    logic [QUO_W-1:0]  quo_r;
    logic              oor;
  } stage_t;

endpackage

// ===== src/nnsa_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnsa_cfg: APB register file
// Holds source and target image sizes, clamping each write to 1..MAX_DIM.
// ----------------------------------------------------------------------------
module nnsa_cfg #(
  parameter int unsigned MAX_DIM = nnsa_pkg::MAX_DIM_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [nnsa_pkg::ADDR_W-1:0] paddr,
  input  logic [nnsa_pkg::DATA_W-1:0] pwdata,
  output logic [nnsa_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output nnsa_pkg::cfg_t              cfg
);
  import nnsa_pkg::*;

  localparam int unsigned CMP_W = 17;

  cfg_t             cfg_r;
  cfg_t             cfg_nxt;
  reg_idx_t         idx;
  logic             wr;
  logic [DIM_W-1:0] wval;
  logic [DIM_W-1:0] rval;

  // Saturate a written dimension into 1..MAX_DIM
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if ({{(CMP_W-DIM_W){1'b0}}, v} > CMP_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end
    return r;
  endfunction

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite && pready;
  assign wval   = clamp_dim(pwdata[DIM_W-1:0]);

  // Decode write
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (idx)
        REG_SRC_W: cfg_nxt.src_w = wval;
        REG_SRC_H: cfg_nxt.src_h = wval;
        REG_TGT_W: cfg_nxt.tgt_w = wval;
        REG_TGT_H: cfg_nxt.tgt_h = wval;
        default: ;
      endcase
    end
  end

  // Hold registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_w <= SRC_W_RST;
      cfg_r.src_h <= SRC_H_RST;
      cfg_r.tgt_w <= TGT_W_RST;
      cfg_r.tgt_h <= TGT_H_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      REG_SRC_W: rval = cfg_r.src_w;
      REG_SRC_H: rval = cfg_r.src_h;
      REG_TGT_W: rval = cfg_r.tgt_w;
      REG_TGT_H: rval = cfg_r.tgt_h;
      default:   rval = '0;
    endcase
  end

  assign prdata = {{(DATA_W-DIM_W){1'b0}}, rval};
  assign cfg    = cfg_r;

  // Stored sizes never leave 1..MAX_DIM; source width and both target sizes are checked nonzero
  a_src_w_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_r.src_w != '0) else $error("source width register is zero");
  a_tgt_w_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_r.tgt_w != '0) else $error("target width register is zero");
  a_tgt_h_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_r.tgt_h != '0) else $error("target height register is zero");

endmodule

// ===== src/nnsa_div_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnsa_div_stage: one restoring-division stage
// Resolves quotient bit BIT of both the column and the row division.
// ----------------------------------------------------------------------------
module nnsa_div_stage #(
  parameter int unsigned BIT = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  nnsa_pkg::cfg_t   cfg,
  input  logic             in_vld,
  input  nnsa_pkg::stage_t in_data,
  output logic             vld_r,
  output nnsa_pkg::stage_t data_r
);
  import nnsa_pkg::*;

  localparam int unsigned CMP_W = PROD_W + 1;

  logic [CMP_W-1:0] dvs_c;
  logic [CMP_W-1:0] dvs_r;
  logic             take_c;
  logic             take_r;
  stage_t           data_nxt;

  // Divisor aligned to this quotient bit
  assign dvs_c  = {{(CMP_W-DIM_W){1'b0}}, cfg.tgt_w} << BIT;
  assign dvs_r  = {{(CMP_W-DIM_W){1'b0}}, cfg.tgt_h} << BIT;
  assign take_c = {1'b0, in_data.rem_c} >= dvs_c;
  assign take_r = {1'b0, in_data.rem_r} >= dvs_r;

  // Subtract where the divisor fits and set the quotient bit
  always_comb begin
    data_nxt = in_data;
    if (take_c) begin
      data_nxt.rem_c      = in_data.rem_c - dvs_c[PROD_W-1:0];
      data_nxt.quo_c[BIT] = 1'b1;
    end
    if (take_r) begin
      data_nxt.rem_r      = in_data.rem_r - dvs_r[PROD_W-1:0];
      data_nxt.quo_r[BIT] = 1'b1;
    end
  end

  // Advance when the stage is free or drains
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  // A request that enters is held until taken
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    en && in_vld |=> vld_r) else $error("request lost entering divider stage");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en && vld_r |=> vld_r && $stable(data_r))
    else $error("stalled divider stage changed");
  a_bit_clear: assert property (@(posedge clk) disable iff (!rst_n)
    en && in_vld && in_data.quo_c[BIT] |=> data_r.quo_c[BIT])
    else $error("quotient bit dropped");

endmodule

// ===== src/nearest_neighbor_scale_address_top.sv =====
`timescale 1ns / 1ps
// Throughput: one request per cycle while out_stall is low; the 13 one-bit division stages set the depth.
// Stall: per-stage enables let bubbles collapse, so requests still enter while
//   a finished result waits at the output.
// Reset: synchronous, active low; clears all stage valids and loads the sizes
//   640 x 480 source, 640 x 480 target.
// ----------------------------------------------------------------------------
// nearest_neighbor_scale_address_top: nearest-neighbor source address generator
// Maps a destination pixel to floor(col*src_w/tgt_w), floor(row*src_h/tgt_h)
// and the row-major source index through a multiply, divide and MAC pipeline.
// ----------------------------------------------------------------------------
module nearest_neighbor_scale_address_top #(
  parameter int unsigned MAX_DIM = nnsa_pkg::MAX_DIM_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // request channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [nnsa_pkg::COORD_W-1:0] in_dest_col,
  input  logic [nnsa_pkg::COORD_W-1:0] in_dest_row,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [nnsa_pkg::COORD_W-1:0] out_src_col,
  output logic [nnsa_pkg::COORD_W-1:0] out_src_row,
  output logic [nnsa_pkg::INDEX_W-1:0] out_src_index,
  output logic                         out_out_of_range,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [nnsa_pkg::ADDR_W-1:0]  paddr,
  input  logic [nnsa_pkg::DATA_W-1:0]  pwdata,
  output logic [nnsa_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import nnsa_pkg::*;

  localparam int unsigned LAST   = QUO_W + 1;   // output stage index
  localparam int unsigned NSTAGE = LAST + 1;
  localparam int unsigned MAC_W  = 2 * DIM_W;

  cfg_t               cfg;
  logic [NSTAGE-1:0]  en;
  logic [NSTAGE-1:0]  vld;
  stage_t             stg [0:QUO_W];
  stage_t             front_nxt;
  logic               front_vld_r;
  stage_t             front_r;
  logic               out_vld_r;
  logic               oor_c;
  logic [MAC_W-1:0]   mac;
  logic [COORD_W-1:0] src_col_r;
  logic [COORD_W-1:0] src_row_r;
  logic [INDEX_W-1:0] src_index_r;
  logic               oor_r;

  nnsa_cfg #(
    .MAX_DIM (MAX_DIM)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Stage enables: a stage moves when empty or when the next one moves
  assign en[LAST] = !vld[LAST] || !out_stall;
  for (genvar k = 0; k < LAST; k++) begin : g_en
    assign en[k] = !vld[k] || en[k+1];
  end
  assign in_stall = !en[0];

  // Front stage: range check and scaling products
  assign oor_c = ({1'b0, in_dest_col} >= cfg.tgt_w) || ({1'b0, in_dest_row} >= cfg.tgt_h);

  always_comb begin
    front_nxt       = '0;
    front_nxt.rem_c = PROD_W'(in_dest_col) * PROD_W'(cfg.src_w);
    front_nxt.rem_r = PROD_W'(in_dest_row) * PROD_W'(cfg.src_h);
    front_nxt.oor   = oor_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_vld_r <= 1'b0;
    end else if (en[0]) begin
      front_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      front_r <= front_nxt;
    end
  end

  assign vld[0] = front_vld_r;
  assign stg[0] = front_r;

  // Divider: one quotient bit per stage, most significant first
  for (genvar k = 1; k <= QUO_W; k++) begin : g_div
    nnsa_div_stage #(
      .BIT (QUO_W - k)
    ) u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en[k]),
      .cfg     (cfg),
      .in_vld  (vld[k-1]),
      .in_data (stg[k-1]),
      .vld_r   (vld[k]),
      .data_r  (stg[k])
    );
  end

  // Output stage: row-major index and zeroing of out-of-range requests
  assign mac = MAC_W'(stg[QUO_W].quo_r) * MAC_W'(cfg.src_w) + MAC_W'(stg[QUO_W].quo_c);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en[LAST]) begin
      out_vld_r <= vld[QUO_W];
    end
  end

  assign vld[LAST] = out_vld_r;

  always_ff @(posedge clk) begin
    if (en[LAST]) begin
      oor_r <= stg[QUO_W].oor;
      if (stg[QUO_W].oor) begin
        src_col_r   <= '0;
        src_row_r   <= '0;
        src_index_r <= '0;
      end else begin
        src_col_r   <= stg[QUO_W].quo_c[COORD_W-1:0];
        src_row_r   <= stg[QUO_W].quo_r[COORD_W-1:0];
        src_index_r <= mac[INDEX_W-1:0];
      end
    end
  end

  assign out_valid        = vld[LAST];
  assign out_src_col      = src_col_r;
  assign out_src_row      = src_row_r;
  assign out_src_index    = src_index_r;
  assign out_out_of_range = oor_r;

  // Out-of-range results carry zero fields
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |->
      (out_src_col == '0) && (out_src_row == '0) && (out_src_index == '0))
    else $error("out-of-range result with nonzero fields");
  // Input is only held off when the front stage is occupied
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> vld[0]) else $error("input stalled with empty front stage");
  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("result valid after reset");
  // A waiting result is taken before the output stage reloads
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("stalled result dropped");

endmodule

// ===== bench/nearest_neighbor_scale_address_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_neighbor_scale_address_top_tb: self-checking bench of the scaler
// Streams destination pixels through the address scaler under random bursts
// and output stalls, predicts each source address from its own copy of the
// image sizes, and checks every result in order. Sizes are reprogrammed over
// the APB port between phases and read back.
// ----------------------------------------------------------------------------

// One source address as the block reports it
typedef struct packed {
  logic [nnsa_pkg::COORD_W-1:0] col;
  logic [nnsa_pkg::COORD_W-1:0] row;
  logic [nnsa_pkg::INDEX_W-1:0] index;
  logic                         oor;
} src_pixel_t;

// Tracks the programmed sizes and the source addresses still in flight
class pixel_map_scoreboard;
  logic [nnsa_pkg::DIM_W-1:0] src_w = nnsa_pkg::SRC_W_RST;
  logic [nnsa_pkg::DIM_W-1:0] src_h = nnsa_pkg::SRC_H_RST;
  logic [nnsa_pkg::DIM_W-1:0] tgt_w = nnsa_pkg::TGT_W_RST;
  logic [nnsa_pkg::DIM_W-1:0] tgt_h = nnsa_pkg::TGT_H_RST;
  src_pixel_t pending_addr[$];
  int failures = 0;

  // Mask to the register width, then clamp into 1..MAX_DIM
  function logic [nnsa_pkg::DIM_W-1:0] clamp_size(bit [31:0] raw);
    logic [nnsa_pkg::DIM_W-1:0] v;
    v = raw[nnsa_pkg::DIM_W-1:0];
    if (v < 1) v = 1;
    if (v > nnsa_pkg::MAX_DIM_DEF) v = nnsa_pkg::DIM_W'(nnsa_pkg::MAX_DIM_DEF);
    return v;
  endfunction

  function void set_size(nnsa_pkg::reg_idx_t idx, bit [31:0] raw);
    case (idx)
      nnsa_pkg::REG_SRC_W: src_w = clamp_size(raw);
      nnsa_pkg::REG_SRC_H: src_h = clamp_size(raw);
      nnsa_pkg::REG_TGT_W: tgt_w = clamp_size(raw);
      nnsa_pkg::REG_TGT_H: tgt_h = clamp_size(raw);
      default: ;
    endcase
  endfunction

  function logic [nnsa_pkg::DIM_W-1:0] size_of(nnsa_pkg::reg_idx_t idx);
    case (idx)
      nnsa_pkg::REG_SRC_W: return src_w;
      nnsa_pkg::REG_SRC_H: return src_h;
      nnsa_pkg::REG_TGT_W: return tgt_w;
      default:             return tgt_h;
    endcase
  endfunction

  // Floor-scale the destination pixel back into the source image
  function src_pixel_t map_to_source(logic [nnsa_pkg::COORD_W-1:0] dc,
                                     logic [nnsa_pkg::COORD_W-1:0] dr);
    src_pixel_t p;
    longint unsigned c;
    longint unsigned r;
    p = '0;
    if (dc >= tgt_w || dr >= tgt_h) begin
      p.oor = 1'b1;
    end else begin
      c = dc;
      r = dr;
      c = (c * src_w) / tgt_w;
      r = (r * src_h) / tgt_h;
      p.col   = c[nnsa_pkg::COORD_W-1:0];
      p.row   = r[nnsa_pkg::COORD_W-1:0];
      p.index = nnsa_pkg::INDEX_W'(r * src_w + c);
    end
    return p;
  endfunction

  function void note_request(logic [nnsa_pkg::COORD_W-1:0] dc,
                             logic [nnsa_pkg::COORD_W-1:0] dr);
    pending_addr.push_back(map_to_source(dc, dr));
  endfunction

  function void check_result(src_pixel_t got);
    src_pixel_t exp;
    if (pending_addr.size() == 0) begin
      $error("unexpected result: col %0d row %0d index %0d oor %0b",
             got.col, got.row, got.index, got.oor);
      failures++;
      return;
    end
    exp = pending_addr.pop_front();
    if (got.col !== exp.col) begin
      $error("src_col mismatch: expected %0d, got %0d", exp.col, got.col);
      failures++;
    end
    if (got.row !== exp.row) begin
      $error("src_row mismatch: expected %0d, got %0d", exp.row, got.row);
      failures++;
    end
    if (got.index !== exp.index) begin
      $error("src_index mismatch: expected %0d, got %0d", exp.index, got.index);
      failures++;
    end
    if (got.oor !== exp.oor) begin
      $error("out_of_range mismatch: expected %0b, got %0b", exp.oor, got.oor);
      failures++;
    end
  endfunction

  function int outstanding();
    return pending_addr.size();
  endfunction
endclass

module nearest_neighbor_scale_address_top_tb;
  import nnsa_pkg::*;

  localparam int LATENCY     = 14;
  localparam int NUM_PHASES  = 12;
  localparam int PHASE_ITEMS = 155;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [COORD_W-1:0]   in_dest_col = '0;
  logic [COORD_W-1:0]   in_dest_row = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [COORD_W-1:0]   out_src_col;
  logic [COORD_W-1:0]   out_src_row;
  logic [INDEX_W-1:0]   out_src_index;
  logic                 out_out_of_range;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_W-1:0]    paddr = '0;
  logic [DATA_W-1:0]    pwdata = '0;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;

  pixel_map_scoreboard sb = new();

  stall_mode_t stall_mode = STALL_NONE;
  int          stall_left = 0;
  int          burst_left = 1;

  nearest_neighbor_scale_address_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_dest_col      (in_dest_col),
    .in_dest_row      (in_dest_row),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_src_col      (out_src_col),
    .out_src_row      (out_src_row),
    .out_src_index    (out_src_index),
    .out_out_of_range (out_out_of_range),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predict every accepted request
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_request(in_dest_col, in_dest_row);
  end

  // Check every accepted result
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result({out_src_col, out_src_row, out_src_index, out_out_of_range});
  end

  // Switch the output stall pattern when its random run length counts out
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY:    out_stall <= ($urandom_range(0, 4) != 0);
      STALL_PERIODIC: out_stall <= (stall_left[2:0] < 3);
      default:        out_stall <= 1'b0;
    endcase
  end

  // Hold off new requests until every expected result is back, then settle
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() > 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  // Send one request and wait for its acceptance
  task automatic send_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row);
    in_valid    <= 1'b1;
    in_dest_col <= col;
    in_dest_row <= row;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Send one request, then close the burst with a random gap when it ends
  task automatic stream_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row);
    int gap;
    send_pixel(col, row);
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
  endtask

  // Read a size register back and compare with the clamped value
  task automatic check_size(input reg_idx_t idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== DATA_W'(sb.size_of(idx))) begin
      $error("%s readback mismatch: expected %0d, got %0d",
             idx.name(), sb.size_of(idx), prdata);
      sb.failures++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Program one size register, then read it back
  task automatic write_size(input reg_idx_t idx, input bit [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_size(idx, value);
    @(posedge clk);
    check_size(idx);
  endtask

  task automatic write_sizes(input bit [31:0] sw, input bit [31:0] sh,
                             input bit [31:0] tw, input bit [31:0] th);
    write_size(REG_SRC_W, sw);
    write_size(REG_SRC_H, sh);
    write_size(REG_TGT_W, tw);
    write_size(REG_TGT_H, th);
  endtask

  // Size value: mostly legal, with extremes and out-of-range writes mixed in
  function automatic bit [31:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return 1;
      1:       return MAX_DIM_DEF;
      2:       return 0;
      3:       return $urandom_range(MAX_DIM_DEF + 1, 8191);
      4:       return $urandom;
      5, 6:    return $urandom_range(1, 16);
      default: return $urandom_range(1, MAX_DIM_DEF);
    endcase
  endfunction

  // Destination pixel: mostly inside the target, some noise and edge misses
  task automatic pick_pixel(output logic [COORD_W-1:0] col, output logic [COORD_W-1:0] row);
    int kind;
    kind = $urandom_range(0, 99);
    col  = COORD_W'($urandom_range(0, sb.tgt_w - 1));
    row  = COORD_W'($urandom_range(0, sb.tgt_h - 1));
    if (kind >= 85 && kind < 93) begin
      col = COORD_W'($urandom);
      row = COORD_W'($urandom);
    end else if (kind >= 93 && kind < 97) begin
      if (sb.tgt_w < MAX_DIM_DEF) col = COORD_W'($urandom_range(sb.tgt_w, MAX_DIM_DEF - 1));
      else col = COORD_W'($urandom);
    end else if (kind >= 97) begin
      if (sb.tgt_h < MAX_DIM_DEF) row = COORD_W'($urandom_range(sb.tgt_h, MAX_DIM_DEF - 1));
      else row = COORD_W'($urandom);
    end
  endtask

  initial begin
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    int pause_at;

    // Reset once, then check the reset sizes
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_size(REG_SRC_W);
    check_size(REG_SRC_H);
    check_size(REG_TGT_W);
    check_size(REG_TGT_H);

    // Reset sizes: corners and just past the target edges
    stream_pixel(0, 0);
    stream_pixel(639, 479);
    stream_pixel(640, 0);
    stream_pixel(0, 480);
    stream_pixel(4095, 4095);
    stream_pixel(639, 0);
    drain_results();

    // Largest sizes, identity map with alternating bit patterns
    write_sizes(MAX_DIM_DEF, MAX_DIM_DEF, MAX_DIM_DEF, MAX_DIM_DEF);
    stream_pixel(4095, 4095);
    stream_pixel(0, 4095);
    stream_pixel(12'hAAA, 12'h555);
    stream_pixel(12'h555, 12'hAAA);
    drain_results();

    // Shrink to one pixel: only the origin is inside
    write_sizes(MAX_DIM_DEF, MAX_DIM_DEF, 1, 1);
    stream_pixel(0, 0);
    stream_pixel(1, 0);
    stream_pixel(0, 1);
    drain_results();

    // Blow up a single pixel: everything maps to the origin
    write_sizes(1, 1, MAX_DIM_DEF, MAX_DIM_DEF);
    stream_pixel(4095, 4095);
    stream_pixel(2048, 17);
    drain_results();

    // Zero and oversized writes saturate, upper bits are masked off
    write_sizes(0, 8191, 32'hFFFF_E005, 32'h0000_2000);
    stream_pixel(4095, 0);
    stream_pixel(4095, 1);
    stream_pixel(17, 0);
    drain_results();

    // Uneven ratios exercise the floor
    write_sizes(1023, 17, 4095, 3);
    stream_pixel(4094, 2);
    stream_pixel(4095, 2);
    stream_pixel(1, 1);
    drain_results();

    // Random phases with fresh sizes each time
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_sizes(pick_size(), pick_size(), pick_size(), pick_size());
      pause_at = ($urandom_range(0, 1) == 0) ? $urandom_range(10, PHASE_ITEMS - 10) : -1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == pause_at) drain_results();
        pick_pixel(col, row);
        stream_pixel(col, row);
      end
      drain_results();
    end

    // Wrap up: nothing may be left waiting
    if (sb.outstanding() != 0) begin
      $error("%0d expected results never arrived", sb.outstanding());
      sb.failures++;
    end
    if (sb.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Abort a hung run
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
